// ===== rtl/core/dsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types, constants and the CRC-32 byte update for the datagram parser.
// ----------------------------------------------------------------------------
package dsp_pkg;

    typedef enum logic [2:0] {
        PH_VERSION = 3'd0,
        PH_CRC     = 3'd1,
        PH_DCOUNT  = 3'd2,
        PH_DEST    = 3'd3,
        PH_LENGTH  = 3'd4,
        PH_DATA    = 3'd5,
        PH_TRAIL   = 3'd6
    } phase_t;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_VERSION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_CAPACITY    = 1'b1;

    localparam logic [7:0]            VERSION_RESET  = 8'd1;
    localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 17'd4096;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [7:0] FIELD4_LAST = 8'd3;

    // Front-to-back command: one classified byte
    typedef struct packed {
        phase_t      role;
        logic [15:0] idx;
        logic [7:0]  data;
        logic        restart;
        logic        complete;
    } cmd_t;

    typedef struct packed {
        phase_t      role;
        logic [15:0] idx;
        logic [7:0]  data;
        logic        complete;
        logic        valid;
    } res_t;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/dsp_fifo.sv =====
// ----------------------------------------------------------------------------
// dsp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module dsp_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/dsp_front.sv =====
// ----------------------------------------------------------------------------
// dsp_front
// Field walker: tracks the datagram layout and classifies each byte.
// ----------------------------------------------------------------------------
module dsp_front #(
    parameter int unsigned MAX_DATA_BYTES = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [7:0]                      byte_in,
    input  logic                            first_of_datagram,
    input  logic [dsp_pkg::CFG_DATA_W-1:0]  data_capacity,
    output dsp_pkg::cmd_t                   cmd
);
    import dsp_pkg::*;

    localparam int unsigned DW = $clog2(MAX_DATA_BYTES + 1);
    localparam int unsigned CW = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
    localparam logic [CW-1:0] CAP_MAX = CW'(MAX_DATA_BYTES);

    phase_t         phase_reg,  phase_next;
    logic [7:0]     field_count_reg, field_count_next;
    logic [DW-1:0]  data_count_reg,  data_count_next;
    logic [7:0]     dest_count_reg,  dest_count_next;
    logic [31:0]    declared_length_reg, declared_length_next;

    phase_t         phase_cur;
    logic [7:0]     fc_cur;
    logic [DW-1:0]  dc_cur;
    logic [7:0]     fc_inc;
    logic [DW-1:0]  dc_inc;
    logic [CW-1:0]  cap_ext;
    logic [CW-1:0]  eff_cap;

    // Restart applies before the byte is handled
    assign phase_cur = first_of_datagram ? PH_VERSION : phase_reg;
    assign fc_cur    = first_of_datagram ? '0 : field_count_reg;
    assign dc_cur    = first_of_datagram ? '0 : data_count_reg;
    assign fc_inc    = fc_cur + 8'd1;
    assign dc_inc    = dc_cur + 1'b1;

    always_comb
    begin
        cap_ext = CW'(data_capacity);
        eff_cap = cap_ext;
        if (cap_ext == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (cap_ext > CAP_MAX)
        begin
            eff_cap = CAP_MAX;
        end
    end

    // Next state
    always_comb
    begin
        phase_next           = phase_cur;
        field_count_next     = fc_cur;
        data_count_next      = dc_cur;
        dest_count_next      = dest_count_reg;
        declared_length_next = declared_length_reg;
        unique case (phase_cur)
            PH_VERSION:
            begin
                field_count_next = '0;
                phase_next       = PH_CRC;
            end
            PH_CRC:
            begin
                field_count_next = fc_inc;
                if (fc_cur >= FIELD4_LAST)
                begin
                    field_count_next = '0;
                    phase_next       = PH_DCOUNT;
                end
            end
            PH_DCOUNT:
            begin
                dest_count_next  = byte_in;
                field_count_next = '0;
                phase_next       = (byte_in == 8'd0) ? PH_LENGTH : PH_DEST;
            end
            PH_DEST:
            begin
                field_count_next = fc_inc;
                if (fc_inc >= dest_count_reg)
                begin
                    field_count_next = '0;
                    phase_next       = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                declared_length_next = {declared_length_reg[23:0], byte_in};
                field_count_next     = fc_inc;
                if (fc_cur >= FIELD4_LAST)
                begin
                    field_count_next = '0;
                    data_count_next  = '0;
                    phase_next = (declared_length_next == 32'd0) ? PH_TRAIL : PH_DATA;
                end
            end
            PH_DATA:
            begin
                data_count_next = dc_inc;
                if ((32'(dc_inc) == declared_length_reg) || (CW'(dc_inc) >= eff_cap))
                begin
                    phase_next = PH_TRAIL;
                end
            end
            default:
            begin
                phase_next = PH_TRAIL;
            end
        endcase
    end

    // Command fields
    always_comb
    begin
        cmd.data     = byte_in;
        cmd.restart  = first_of_datagram;
        cmd.role     = phase_cur;
        cmd.idx      = '0;
        unique case (phase_cur)
            PH_CRC, PH_DEST, PH_LENGTH:
            begin
                cmd.idx = {8'd0, fc_cur};
            end
            PH_DATA:
            begin
                cmd.idx = 16'(dc_cur);
            end
            PH_VERSION, PH_DCOUNT, PH_TRAIL:
            begin
                cmd.idx = '0;
            end
            default:
            begin
                cmd.role = PH_TRAIL;
            end
        endcase
        cmd.complete = ((phase_next == PH_DATA) || (phase_next == PH_TRAIL)) &&
                       (32'(data_count_next) == declared_length_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_VERSION;
            field_count_reg     <= '0;
            data_count_reg      <= '0;
            dest_count_reg      <= '0;
            declared_length_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg           <= phase_next;
            field_count_reg     <= field_count_next;
            data_count_reg      <= data_count_next;
            dest_count_reg      <= dest_count_next;
            declared_length_reg <= declared_length_next;
        end
    end

endmodule

// ===== rtl/core/dsp_back.sv =====
// ----------------------------------------------------------------------------
// dsp_back
// Checker stage: runs the CRC-32, captures version and CRC, builds results.
// ----------------------------------------------------------------------------
module dsp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  dsp_pkg::cmd_t  cmd,
    input  logic [7:0]     expected_version,
    output dsp_pkg::res_t  res
);
    import dsp_pkg::*;

    logic [31:0] running_crc_reg,  running_crc_next;
    logic [31:0] received_crc_reg, received_crc_next;
    logic [7:0]  seen_version_reg, seen_version_next;
    logic [31:0] crc_cur;

    assign crc_cur = cmd.restart ? CRC_INIT : running_crc_reg;

    always_comb
    begin
        running_crc_next  = crc_cur;
        received_crc_next = received_crc_reg;
        seen_version_next = seen_version_reg;
        unique case (cmd.role)
            PH_VERSION:
            begin
                seen_version_next = cmd.data;
            end
            PH_CRC:
            begin
                received_crc_next = {received_crc_reg[23:0], cmd.data};
            end
            PH_DCOUNT, PH_DEST, PH_LENGTH, PH_DATA:
            begin
                running_crc_next = crc_byte(crc_cur, cmd.data);
            end
            default:
            begin
                running_crc_next = crc_cur;
            end
        endcase
    end

    always_comb
    begin
        res.role     = cmd.role;
        res.idx      = cmd.idx;
        res.data     = cmd.data;
        res.complete = cmd.complete;
        res.valid    = ((running_crc_next ^ CRC_INIT) == received_crc_next) &&
                       (seen_version_next == expected_version);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg  <= CRC_INIT;
            received_crc_reg <= '0;
            seen_version_reg <= '0;
        end
        else if (go)
        begin
            running_crc_reg  <= running_crc_next;
            received_crc_reg <= received_crc_next;
            seen_version_reg <= seen_version_next;
        end
    end

endmodule

// ===== rtl/core/datagram_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// datagram_stream_parser_top
// Byte-stream datagram parser with CRC-32 and version check.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive byte_in and first_of_datagram, raise push; a
//   transaction happens on a clock edge with push high and full low.
//   Result queue side: while empty is low the oldest result sits on
//   byte_role, field_index, byte_out, is_complete and is_valid; pop high
//   on an edge takes it.
//   Config: cfg_wr_en with cfg_addr 0 writes expected_version, cfg_addr 1
//   writes data_capacity; write only while the block is idle.
//   A byte pushed into an idle block passes the command queue and then the
//   result queue, where it shows on the result ports and can be popped.
//   Throughput: one byte per cycle while full is low, set by the byte-wide
//   combinational CRC update in the back stage and the front's field walker.
//   A two-entry command queue sits between the stages and a two-entry result
//   queue at the output, so the front keeps taking bytes while the output
//   is stalled until both queues fill; then full rises.
//   Reset: parser in version phase, CRC at all ones, queues empty,
//   expected_version = 1, data_capacity = 4096.
// ----------------------------------------------------------------------------
module datagram_stream_parser_top #(
    parameter int unsigned MAX_DATA_BYTES = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      byte_in,
    input  logic                            first_of_datagram,
    input  logic                            pop,
    output logic                            empty,
    output logic [2:0]                      byte_role,
    output logic [15:0]                     field_index,
    output logic [7:0]                      byte_out,
    output logic                            is_complete,
    output logic                            is_valid,
    input  logic                            cfg_wr_en,
    input  logic [dsp_pkg::CFG_INDEX_W-1:0] cfg_addr,
    input  logic [dsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import dsp_pkg::*;

    localparam int unsigned CMD_W = $bits(cmd_t);
    localparam int unsigned RES_W = $bits(res_t);

    logic [7:0]            expected_version_reg;
    logic [CFG_DATA_W-1:0] data_capacity_reg;

    cmd_t             cmd_in;
    cmd_t             cmd_q;
    logic [CMD_W-1:0] cmd_rd_data;
    logic             cmd_full;
    logic             cmd_empty;
    res_t             res_in;
    res_t             res_q;
    logic [RES_W-1:0] res_rd_data;
    logic             res_full;
    logic             res_empty;
    logic             in_go;
    logic             back_go;

    assign in_go   = push && !cmd_full;
    assign back_go = !cmd_empty && !res_full;
    assign full    = cmd_full;
    assign empty   = res_empty;
    assign cmd_q   = cmd_rd_data;
    assign res_q   = res_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_version_reg <= VERSION_RESET;
            data_capacity_reg    <= CAPACITY_RESET;
        end
        else if (cfg_wr_en)
        begin
            priority if (cfg_addr == CFG_EXPECTED_VERSION)
            begin
                expected_version_reg <= cfg_wdata[7:0];
            end
            else if (cfg_addr == CFG_DATA_CAPACITY)
            begin
                data_capacity_reg <= cfg_wdata;
            end
        end
    end

    dsp_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (in_go),
        .byte_in           (byte_in),
        .first_of_datagram (first_of_datagram),
        .data_capacity     (data_capacity_reg),
        .cmd               (cmd_in)
    );

    dsp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_go),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (back_go),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    dsp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .go               (back_go),
        .cmd              (cmd_q),
        .expected_version (expected_version_reg),
        .res              (res_in)
    );

    dsp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_go),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (res_empty)
    );

    assign byte_role   = res_q.role;
    assign field_index = res_q.idx;
    assign byte_out    = res_q.data;
    assign is_complete = res_q.complete;
    assign is_valid    = res_q.valid;

`ifndef SYNTHESIS
    // A byte entering an empty pipeline passes the command queue and can then be popped from the result queue
    a_idle_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && cmd_empty && res_empty) |=> ##1 !empty)
        else $error("pushed byte did not reach the result queue in time");

    // Completion is only reported at the end of the length field or later
    a_complete_role: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_complete) |->
            (byte_role == PH_LENGTH || byte_role == PH_DATA || byte_role == PH_TRAIL))
        else $error("complete flag on a byte before the length field ended");

    // A restart byte is always classified as the version byte
    a_restart_version: assert property (@(posedge clk) disable iff (!rst_n)
        (in_go && first_of_datagram) |-> (cmd_in.role == PH_VERSION))
        else $error("restart byte not classified as version");
`endif

endmodule

// ===== verif/datagram_stream_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datagram_stream_parser_top_test
// Self-checking bench for the datagram stream parser. Byte streams are built
// from whole, truncated and noisy datagrams, pushed through the input queue
// and tracked by a cycle-free parser model. Every popped result is checked
// field by field against the oldest predicted one. Registers are swept
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module datagram_stream_parser_top_test;
    import dsp_pkg::*;

    localparam int unsigned DATA_LIMIT   = 65536;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    logic                   clk               = 1'b0;
    logic                   rst_n             = 1'b0;
    logic                   push              = 1'b0;
    logic                   full;
    logic [7:0]             byte_in           = 8'd0;
    logic                   first_of_datagram = 1'b0;
    logic                   pop               = 1'b0;
    logic                   empty;
    logic [2:0]             byte_role;
    logic [15:0]            field_index;
    logic [7:0]             byte_out;
    logic                   is_complete;
    logic                   is_valid;
    logic                   cfg_wr_en         = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_addr          = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata         = '0;

    // Parser model state and its register copies
    phase_t          parse_phase;
    logic [7:0]      field_pos;
    logic [31:0]     data_seen;
    logic [31:0]     crc_field;
    logic [31:0]     crc_acc;
    logic [7:0]      version_seen;
    logic [7:0]      dest_total;
    logic [31:0]     length_field;
    logic [7:0]      want_version;
    logic [16:0]     cap_setting;

    res_t            expected_results[$];
    res_t            head_result;
    logic [7:0]      frame_bytes[$];

    bit              stall_enable   = 1'b1;
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count    = 0;
    int unsigned     sent_items     = 0;
    int unsigned     parsed_items   = 0;
    int unsigned     valid_count    = 0;
    int unsigned     complete_count = 0;
    int unsigned     reg_writes     = 0;

    datagram_stream_parser_top #(
        .MAX_DATA_BYTES(DATA_LIMIT)
    ) i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .byte_in           (byte_in),
        .first_of_datagram (first_of_datagram),
        .pop               (pop),
        .empty             (empty),
        .byte_role         (byte_role),
        .field_index       (field_index),
        .byte_out          (byte_out),
        .is_complete       (is_complete),
        .is_valid          (is_valid),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bit-serial reflected CRC-32: feed data bits LSB first
    function automatic logic [31:0] crc32_advance(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ ((c[0] ^ b[k]) ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [31:0] capacity_limit();
        logic [31:0] c;
        c = {15'd0, cap_setting};
        if (c == 32'd0)
            c = 32'd1;
        if (c > DATA_LIMIT)
            c = DATA_LIMIT;
        return c;
    endfunction

    function automatic void reset_parser_model();
        parse_phase  = PH_VERSION;
        field_pos    = 8'd0;
        data_seen    = 32'd0;
        crc_field    = 32'd0;
        crc_acc      = CRC_INIT;
        version_seen = 8'd0;
        dest_total   = 8'd0;
        length_field = 32'd0;
        want_version = 8'd1;
        cap_setting  = 17'd4096;
    endfunction

    // Classify one byte and advance the field walker
    function automatic res_t predict_byte(input logic [7:0] b, input logic first);
        res_t r;
        if (first)
        begin
            parse_phase = PH_VERSION;
            field_pos   = 8'd0;
            data_seen   = 32'd0;
            crc_acc     = CRC_INIT;
        end
        r.role = parse_phase;
        r.idx  = 16'd0;
        r.data = b;
        case (parse_phase)
            PH_VERSION:
            begin
                version_seen = b;
                field_pos    = 8'd0;
                parse_phase  = PH_CRC;
            end
            PH_CRC:
            begin
                r.idx     = {8'd0, field_pos};
                crc_field = {crc_field[23:0], b};
                field_pos = field_pos + 8'd1;
                if (field_pos >= 8'd4)
                begin
                    field_pos   = 8'd0;
                    parse_phase = PH_DCOUNT;
                end
            end
            PH_DCOUNT:
            begin
                dest_total  = b;
                crc_acc     = crc32_advance(crc_acc, b);
                field_pos   = 8'd0;
                parse_phase = (b == 8'd0) ? PH_LENGTH : PH_DEST;
            end
            PH_DEST:
            begin
                r.idx     = {8'd0, field_pos};
                crc_acc   = crc32_advance(crc_acc, b);
                field_pos = field_pos + 8'd1;
                if (field_pos >= dest_total)
                begin
                    field_pos   = 8'd0;
                    parse_phase = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                r.idx        = {8'd0, field_pos};
                length_field = {length_field[23:0], b};
                crc_acc      = crc32_advance(crc_acc, b);
                field_pos    = field_pos + 8'd1;
                if (field_pos >= 8'd4)
                begin
                    field_pos   = 8'd0;
                    data_seen   = 32'd0;
                    parse_phase = (length_field == 32'd0) ? PH_TRAIL : PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.idx     = data_seen[15:0];
                crc_acc   = crc32_advance(crc_acc, b);
                data_seen = data_seen + 32'd1;
                if (data_seen == length_field || data_seen >= capacity_limit())
                    parse_phase = PH_TRAIL;
            end
            default:
            begin
                r.role      = PH_TRAIL;
                parse_phase = PH_TRAIL;
            end
        endcase
        r.complete = (parse_phase == PH_DATA || parse_phase == PH_TRAIL) &&
                     (data_seen == length_field);
        r.valid    = ((crc_acc ^ CRC_INIT) == crc_field) && (version_seen == want_version);
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        res_t predicted;
        while (stall_enable && ($urandom_range(99) < 36))
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push              <= 1'b1;
        byte_in           <= b;
        first_of_datagram <= first;
        do @(posedge clk); while (full);
        predicted = predict_byte(b, first);
        expected_results.push_back(predicted);
        sent_items++;
        if (predicted.role != PH_TRAIL)
            parsed_items++;
        if (predicted.valid)
            valid_count++;
        if (predicted.complete)
            complete_count++;
    endtask

    // Drop push and hold until every predicted result has been popped
    task automatic wait_for_idle();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_for_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_EXPECTED_VERSION)
            want_version = value[7:0];
        else
            cap_setting = value;
        reg_writes++;
    endtask

    // Assemble version, CRC and body; the CRC covers what the parser will hash
    task automatic build_frame(input logic [7:0] ver, input int unsigned ndest,
                               input logic [31:0] len, input int unsigned ndata,
                               input bit bad_crc);
        logic [7:0]  body[$];
        logic [31:0] crc;
        int unsigned covered;
        body.push_back(8'(ndest));
        repeat (ndest) body.push_back(8'($urandom_range(255)));
        body.push_back(len[31:24]);
        body.push_back(len[23:16]);
        body.push_back(len[15:8]);
        body.push_back(len[7:0]);
        repeat (ndata) body.push_back(8'($urandom_range(255)));
        covered = 5 + ndest + ((ndata < capacity_limit()) ? ndata : capacity_limit());
        crc = CRC_INIT;
        for (int unsigned j = 0; j < covered; j++)
            crc = crc32_advance(crc, body[j]);
        crc = ~crc;
        if (bad_crc)
            crc = crc ^ (32'd1 << $urandom_range(31));
        frame_bytes.delete();
        frame_bytes.push_back(ver);
        frame_bytes.push_back(crc[31:24]);
        frame_bytes.push_back(crc[23:16]);
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
        foreach (body[j])
            frame_bytes.push_back(body[j]);
    endtask

    task automatic send_frame(input bit mark_first);
        foreach (frame_bytes[j])
            send_byte(frame_bytes[j], (j == 0) && mark_first);
    endtask

    task automatic send_random_datagram();
        int unsigned kind;
        int unsigned pick;
        int unsigned ndest;
        int unsigned ndata;
        int unsigned cut;
        logic [31:0] len;
        logic [7:0]  ver;
        kind = $urandom_range(99);
        if (kind >= 88)
        begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            return;
        end
        ver  = ($urandom_range(99) < 75) ? want_version : 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 20)
            ndest = 0;
        else if (pick < 96)
            ndest = $urandom_range(1, 8);
        else
            ndest = $urandom_range(200, 255);
        pick = $urandom_range(99);
        if (pick < 15)
            len = 32'd0;
        else if (pick < 85)
            len = $urandom_range(1, 24);
        else
            len = $urandom();
        ndata = (len < 32'd64) ? len : 64;
        build_frame(ver, ndest, len, ndata, $urandom_range(99) < 20);
        if (kind >= 73)
        begin
            // cut short; the next datagram restarts mid-field
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        else
        begin
            repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(255)));
        end
        send_frame($urandom_range(99) < 95);
    endtask

    task automatic test_reset_defaults();
        stall_enable = 1'b1;
        build_frame(8'd1, 2, 32'd3, 3, 1'b0);
        send_frame(1'b1);
        // long declared length with only part of the data sent; complete stays low
        build_frame(8'd1, 0, 32'd4100, 20, 1'b0);
        send_frame(1'b1);
    endtask

    task automatic test_directed_fields();
        build_frame(8'hFF, 0, 32'd0, 0, 1'b0);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        send_frame(1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        build_frame(8'h01, 1, 32'd1, 1, 1'b0);
        send_frame(1'b1);
    endtask

    task automatic run_setting(input logic [7:0] ver, input logic [16:0] cap);
        write_register(CFG_EXPECTED_VERSION, {9'd0, ver});
        write_register(CFG_DATA_CAPACITY, cap);
        build_frame(want_version, 1, 32'd10, 10, 1'b0);
        send_frame(1'b1);
        build_frame(want_version, 0, 32'd0, 0, 1'b0);
        send_frame(1'b1);
        build_frame(~want_version, 2, 32'd3, 3, 1'b0);
        send_frame(1'b1);
        build_frame(want_version, 0, 32'd2, 2, 1'b1);
        send_frame(1'b1);
    endtask

    task automatic test_register_extremes();
        run_setting(8'h00, 17'd0);
        run_setting(8'hFF, 17'd1);
        run_setting(8'h5A, 17'd2);
        run_setting(8'h01, 17'd65536);
        run_setting(8'hFF, 17'h1FFFF);
        run_setting(8'h33, 17'd7);
    endtask

    task automatic test_random_stream();
        int unsigned start_count;
        int unsigned target;
        int unsigned pick;
        start_count = sent_items;
        for (int stretch = 0; sent_items - start_count < RANDOM_ITEMS; stretch++)
        begin
            stall_enable = (stretch != 2);
            pick = $urandom_range(99);
            write_register(CFG_EXPECTED_VERSION,
                           (pick < 10) ? 17'd0 :
                           (pick < 20) ? 17'd255 : 17'($urandom_range(255)));
            pick = $urandom_range(99);
            if (pick < 70)
                write_register(CFG_DATA_CAPACITY, 17'($urandom_range(1, 40)));
            else if (pick < 85)
                write_register(CFG_DATA_CAPACITY, 17'($urandom_range(0, 131071)));
            else
                write_register(CFG_DATA_CAPACITY, 17'($urandom_range(41, 300)));
            target = sent_items + 250;
            while (sent_items < target && sent_items - start_count < RANDOM_ITEMS)
                send_random_datagram();
        end
    endtask

    // Capacity above the maximum clamps; a frame runs to its declared length
    task automatic test_capacity_clamp();
        stall_enable = 1'b0;
        write_register(CFG_DATA_CAPACITY, 17'h1FFFF);
        build_frame(want_version, 1, 32'd40, 40, 1'b0);
        send_frame(1'b1);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !stall_enable || ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none actual role %0d index %0h byte %0h",
                         $time, byte_role, field_index, byte_out);
                mismatch_count++;
            end
            else
            begin
                head_result = expected_results.pop_front();
                compare_field("byte_role", 32'(head_result.role), 32'(byte_role));
                compare_field("field_index", 32'(head_result.idx), 32'(field_index));
                compare_field("byte_out", 32'(head_result.data), 32'(byte_out));
                compare_field("is_complete", 32'(head_result.complete), 32'(is_complete));
                compare_field("is_valid", 32'(head_result.valid), 32'(is_valid));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        reset_parser_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_fields();
        test_register_extremes();
        test_random_stream();
        test_capacity_clamp();
        wait_for_idle();
        repeat (8) @(posedge clk);
        $display("Checked %0d byte transactions (%0d inside fields, %0d valid, %0d complete)",
                 sent_items, parsed_items, valid_count, complete_count);
        $display("across %0d register writes; %0d mismatches", reg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== datagram_stream_parser_top.f =====
rtl/core/dsp_pkg.sv
rtl/core/dsp_fifo.sv
rtl/core/dsp_front.sv
rtl/core/dsp_back.sv
rtl/core/datagram_stream_parser_top.sv
verif/datagram_stream_parser_top_test.sv
